// File: sv/tamps_pkg.sv
package tamps_pkg;

   localparam int FRAC_BITS = 16;

   localparam logic [1:0] PLAN_NONE = 2'd0;
   localparam logic [1:0] PLAN_ONE  = 2'd1;
   localparam logic [1:0] PLAN_TWO  = 2'd2;

   localparam logic [30:0] COAST_MAX = 31'h7FFF_FFFF;

   localparam int DIV1_BITS   = 98;
   localparam int DIV1_PER    = 2;
   localparam int DIV1_STAGES = DIV1_BITS / DIV1_PER;

   localparam int SQRT_BITS   = 50;
   localparam int SQRT_PER    = 2;
   localparam int SQRT_STAGES = SQRT_BITS / SQRT_PER;

   localparam int DIV2_BITS   = 33;
   localparam int DIV2_PER    = 1;
   localparam int DIV2_STAGES = DIV2_BITS / DIV2_PER;

   typedef struct packed {
      logic        [1:0]  stop_flags;
      logic        [30:0] accel_time_one;
      logic        [30:0] coast_time_one;
      logic        [30:0] decel_time_one;
      logic signed [31:0] accel_rate_one;
      logic signed [31:0] start_speed_one;
      logic        [30:0] accel_time_two;
      logic        [30:0] coast_time_two;
      logic        [30:0] decel_time_two;
      logic signed [31:0] accel_rate_two;
      logic signed [31:0] start_speed_two;
      logic        [30:0] speed_limit;
   } req_type;

   typedef struct packed {
      logic [1:0]  updated_plan;
      logic [30:0] new_accel_time;
      logic [30:0] new_decel_time;
      logic [30:0] new_coast_time;
   } rsp_type;

endpackage

// File: sv/two_axis_motion_plan_sync_unit.sv
// channel   | valid      | stall      | payload
// request   | req_valid  | req_stall  | req_data  (req_type)
// response  | rsp_valid  | rsp_stall  | rsp_data  (rsp_type)
//
// one request per cycle while req_stall is low; stages in order: 6 setup stages, 50 stages of the
// 98-bit divider at 2 bits each, 26 of the 50-bit square root at 2 bits each,
// 6 stages of shift solve and products, 34 of the 33-bit divider, 1 output
// synchronous active-high reset clears the valid bits, including the output valid bit, but not the output data
// the pipeline holds only while its last stage is full and the response is stalled
module two_axis_motion_plan_sync_unit import tamps_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef struct packed {
      logic               chg;
      logic        [1:0]  which;
      logic        [30:0] ta;
      logic        [30:0] td;
      logic signed [31:0] a;
      logic signed [31:0] v;
      logic        [30:0] lim;
      logic        [33:0] p;
   } plan_type;

   typedef struct packed {
      req_type     rq;
      logic [32:0] dur1;
      logic [32:0] dur2;
   } s1_type;

   typedef struct packed {
      plan_type    pl;
      logic [30:0] tc;
      logic [32:0] dd;
      logic [30:0] vlim;
   } s2_type;

   typedef struct packed {
      plan_type           pl;
      logic signed [63:0] at;
      logic        [32:0] dd;
      logic        [30:0] vlim;
   } s3_type;

   typedef struct packed {
      plan_type           pl;
      logic signed [63:0] w;
      logic        [67:0] pp;
      logic        [32:0] dd;
      logic        [30:0] vlim;
   } s4_type;

   typedef struct packed {
      plan_type    pl;
      logic [67:0] pp;
      logic [62:0] wmag;
      logic [32:0] dd;
      logic [30:0] vlim;
   } s5_type;

   typedef struct packed {
      plan_type    pl;
      logic [67:0] pp;
      logic [64:0] mlo;
      logic [63:0] mhi;
      logic [30:0] vlim;
   } s6_type;

   typedef struct packed {
      plan_type    pl;
      logic [67:0] pp;
      logic [31:0] rem;
      logic [97:0] n;
      logic [30:0] vlim;
   } dv1_type;

   typedef struct packed {
      plan_type    pl;
      logic [52:0] rem;
      logic [99:0] rad;
      logic [49:0] root;
   } sq_type;

   typedef struct packed {
      plan_type    pl;
      logic [48:0] x0;
   } s9_type;

   typedef struct packed {
      logic               chg;
      logic        [1:0]  which;
      logic        [30:0] ta;
      logic        [30:0] td;
      logic signed [31:0] a;
      logic signed [31:0] v;
      logic        [30:0] x;
   } s10_type;

   typedef struct packed {
      logic               chg;
      logic        [1:0]  which;
      logic        [30:0] acc;
      logic        [30:0] dec;
      logic signed [31:0] a;
      logic        [31:0] amag;
      logic signed [31:0] v;
      logic        [30:0] x;
   } s11_type;

   typedef struct packed {
      logic               chg;
      logic        [1:0]  which;
      logic        [30:0] acc;
      logic        [30:0] dec;
      logic               aneg;
      logic signed [63:0] pv;
      logic        [62:0] ax;
      logic signed [31:0] v;
      logic        [30:0] x;
   } s12_type;

   typedef struct packed {
      logic               chg;
      logic        [1:0]  which;
      logic        [30:0] acc;
      logic        [30:0] dec;
      logic               aneg;
      logic signed [63:0] vcs;
      logic        [61:0] nhi;
      logic        [62:0] nlo;
      logic        [30:0] x;
   } s13_type;

   typedef struct packed {
      logic        chg;
      logic [1:0]  which;
      logic [30:0] acc;
      logic [30:0] dec;
      logic        neg;
      logic        vz;
      logic [63:0] den;
      logic [93:0] num;
      logic [30:0] x;
   } s14_type;

   typedef struct packed {
      logic        chg;
      logic [1:0]  which;
      logic [30:0] acc;
      logic [30:0] dec;
      logic        neg;
      logic        vz;
      logic        big;
      logic [63:0] den;
      logic [63:0] rem;
      logic [32:0] n;
      logic [30:0] x;
   } dv2_type;

   s1_type  s1_ff,  s1_in;
   s2_type  s2_ff,  s2_in;
   s3_type  s3_ff,  s3_in;
   s4_type  s4_ff,  s4_in;
   s5_type  s5_ff,  s5_in;
   s6_type  s6_ff,  s6_in;
   dv1_type d1_ff [DIV1_STAGES+1];
   dv1_type d1_in [DIV1_STAGES+1];
   sq_type  sq_ff [SQRT_STAGES+1];
   sq_type  sq_in [SQRT_STAGES+1];
   s9_type  s9_ff,  s9_in;
   s10_type s10_ff, s10_in;
   s11_type s11_ff, s11_in;
   s12_type s12_ff, s12_in;
   s13_type s13_ff, s13_in;
   s14_type s14_ff, s14_in;
   dv2_type d2_ff [DIV2_STAGES+1];
   dv2_type d2_in [DIV2_STAGES+1];
   rsp_type rsp_data_ff, rsp_data_in;
   logic    rsp_valid_ff;

   logic [5:0]           sa_vld_ff;
   logic [DIV1_STAGES:0] d1_vld_ff;
   logic [SQRT_STAGES:0] sq_vld_ff;
   logic [5:0]           sb_vld_ff;
   logic [DIV2_STAGES:0] d2_vld_ff;

   logic out_free;
   logic adv;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign adv       = out_free || !d2_vld_ff[DIV2_STAGES];
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      req_type     rq;
      logic        ok;
      logic [63:0] wabs;
      logic [63:0] cabs;
      logic [31:0] t1;
      logic [52:0] t2;
      logic [52:0] trial;
      logic [64:0] t3;
      logic [93:0] num;
      logic [32:0] q;
      logic [31:0] two_x;
      logic [32:0] s;
      logic [30:0] c;
      dv1_type     cur1;
      sq_type      cur2;
      dv2_type     cur3;

      // durations
      s1_in.rq   = req_data;
      s1_in.dur1 = 33'(req_data.accel_time_one) + 33'(req_data.coast_time_one)
                 + 33'(req_data.decel_time_one);
      s1_in.dur2 = 33'(req_data.accel_time_two) + 33'(req_data.coast_time_two)
                 + 33'(req_data.decel_time_two);

      // plan choice
      rq = s1_ff.rq;
      ok = (rq.stop_flags == 2'b00) && (rq.speed_limit != 31'd0);
      s2_in = '0;
      s2_in.vlim = rq.speed_limit;
      if ((rq.accel_time_one != 31'd0) && (s1_ff.dur1 < s1_ff.dur2)) begin
         s2_in.pl.which = PLAN_ONE;
         s2_in.pl.ta    = rq.accel_time_one;
         s2_in.tc       = rq.coast_time_one;
         s2_in.pl.td    = rq.decel_time_one;
         s2_in.pl.a     = rq.accel_rate_one;
         s2_in.pl.v     = rq.start_speed_one;
         s2_in.dd       = s1_ff.dur2 - s1_ff.dur1;
      end else if ((rq.accel_time_two != 31'd0) && (s1_ff.dur2 < s1_ff.dur1)) begin
         s2_in.pl.which = PLAN_TWO;
         s2_in.pl.ta    = rq.accel_time_two;
         s2_in.tc       = rq.coast_time_two;
         s2_in.pl.td    = rq.decel_time_two;
         s2_in.pl.a     = rq.accel_rate_two;
         s2_in.pl.v     = rq.start_speed_two;
         s2_in.dd       = s1_ff.dur1 - s1_ff.dur2;
      end else begin
         s2_in.pl.which = PLAN_NONE;
         ok = 1'b0;
      end
      s2_in.pl.chg = ok;

      s3_in        = '0;
      s3_in.pl     = s2_ff.pl;
      s3_in.pl.p   = 34'(s2_ff.tc) + 34'(s2_ff.dd);
      s3_in.pl.lim = (s2_ff.pl.ta <= s2_ff.pl.td) ? s2_ff.pl.ta : s2_ff.pl.td;
      s3_in.at     = $signed(s2_ff.pl.a) * $signed({1'b0, s2_ff.pl.ta});
      s3_in.dd     = s2_ff.dd;
      s3_in.vlim   = s2_ff.vlim;

      s4_in.pl   = s3_ff.pl;
      s4_in.w    = s3_ff.at
                 + ($signed({{32{s3_ff.pl.v[31]}}, s3_ff.pl.v}) <<< FRAC_BITS);
      s4_in.pp   = 68'(s3_ff.pl.p) * 68'(s3_ff.pl.p);
      s4_in.dd   = s3_ff.dd;
      s4_in.vlim = s3_ff.vlim;

      wabs = s4_ff.w[63] ? (64'd0 - s4_ff.w) : s4_ff.w;
      s5_in.pl   = s4_ff.pl;
      s5_in.pp   = s4_ff.pp;
      s5_in.wmag = wabs[62:0];
      s5_in.dd   = s4_ff.dd;
      s5_in.vlim = s4_ff.vlim;

      s6_in.pl   = s5_ff.pl;
      s6_in.pp   = s5_ff.pp;
      s6_in.mlo  = 65'(s5_ff.wmag[31:0]) * 65'(s5_ff.dd);
      s6_in.mhi  = 64'(s5_ff.wmag[62:32]) * 64'(s5_ff.dd);
      s6_in.vlim = s5_ff.vlim;

      // 4*|w|*dd / vlim
      d1_in[0].pl   = s6_ff.pl;
      d1_in[0].pp   = s6_ff.pp;
      d1_in[0].rem  = '0;
      d1_in[0].n    = {(96'(s6_ff.mhi) << 32) + 96'(s6_ff.mlo), 2'b00};
      d1_in[0].vlim = s6_ff.vlim;
      for (int k = 0; k < DIV1_STAGES; k++) begin
         cur1 = d1_ff[k];
         for (int j = 0; j < DIV1_PER; j++) begin
            t1 = {cur1.rem[30:0], cur1.n[97]};
            if (t1 >= {1'b0, cur1.vlim}) begin
               cur1.rem = t1 - {1'b0, cur1.vlim};
               cur1.n   = {cur1.n[96:0], 1'b1};
            end else begin
               cur1.rem = t1;
               cur1.n   = {cur1.n[96:0], 1'b0};
            end
         end
         d1_in[k+1] = cur1;
      end

      // isqrt(p*p + m)
      sq_in[0].pl   = d1_ff[DIV1_STAGES].pl;
      sq_in[0].rem  = '0;
      sq_in[0].rad  = 100'(d1_ff[DIV1_STAGES].pp) + 100'(d1_ff[DIV1_STAGES].n);
      sq_in[0].root = '0;
      for (int k = 0; k < SQRT_STAGES; k++) begin
         cur2 = sq_ff[k];
         for (int j = 0; j < SQRT_PER; j++) begin
            t2    = {cur2.rem[50:0], cur2.rad[99:98]};
            trial = {1'b0, cur2.root, 2'b01};
            cur2.rad = {cur2.rad[97:0], 2'b00};
            if (t2 >= trial) begin
               cur2.rem  = t2 - trial;
               cur2.root = {cur2.root[48:0], 1'b1};
            end else begin
               cur2.rem  = t2;
               cur2.root = {cur2.root[48:0], 1'b0};
            end
         end
         sq_in[k+1] = cur2;
      end

      s9_in.pl = sq_ff[SQRT_STAGES].pl;
      s9_in.x0 = 49'((sq_ff[SQRT_STAGES].root - 50'(sq_ff[SQRT_STAGES].pl.p)) >> 1);

      s10_in.which = s9_ff.pl.which;
      s10_in.ta    = s9_ff.pl.ta;
      s10_in.td    = s9_ff.pl.td;
      s10_in.a     = s9_ff.pl.a;
      s10_in.v     = s9_ff.pl.v;
      s10_in.x     = (s9_ff.x0 > 49'(s9_ff.pl.lim)) ? s9_ff.pl.lim : s9_ff.x0[30:0];
      s10_in.chg   = s9_ff.pl.chg && (s10_in.x != 31'd0);

      s11_in.chg   = s10_ff.chg;
      s11_in.which = s10_ff.which;
      s11_in.acc   = s10_ff.ta - s10_ff.x;
      s11_in.dec   = s10_ff.td - s10_ff.x;
      s11_in.a     = s10_ff.a;
      s11_in.amag  = s10_ff.a[31] ? (32'd0 - s10_ff.a) : s10_ff.a;
      s11_in.v     = s10_ff.v;
      s11_in.x     = s10_ff.x;

      s12_in.chg   = s11_ff.chg;
      s12_in.which = s11_ff.which;
      s12_in.acc   = s11_ff.acc;
      s12_in.dec   = s11_ff.dec;
      s12_in.aneg  = s11_ff.a[31];
      s12_in.pv    = $signed({1'b0, s11_ff.acc}) * $signed(s11_ff.a);
      s12_in.ax    = 63'(s11_ff.amag) * 63'(s11_ff.x);
      s12_in.v     = s11_ff.v;
      s12_in.x     = s11_ff.x;

      s13_in.chg   = s12_ff.chg;
      s13_in.which = s12_ff.which;
      s13_in.acc   = s12_ff.acc;
      s13_in.dec   = s12_ff.dec;
      s13_in.aneg  = s12_ff.aneg;
      s13_in.vcs   = s12_ff.pv
                   + ($signed({{32{s12_ff.v[31]}}, s12_ff.v}) <<< FRAC_BITS);
      s13_in.nhi   = 62'(s12_ff.ax[62:32]) * 62'(s12_ff.x);
      s13_in.nlo   = 63'(s12_ff.ax[31:0]) * 63'(s12_ff.x);
      s13_in.x     = s12_ff.x;

      cabs = s13_ff.vcs[63] ? (64'd0 - s13_ff.vcs) : s13_ff.vcs;
      s14_in.chg   = s13_ff.chg;
      s14_in.which = s13_ff.which;
      s14_in.acc   = s13_ff.acc;
      s14_in.dec   = s13_ff.dec;
      s14_in.neg   = s13_ff.aneg != s13_ff.vcs[63];
      s14_in.vz    = s13_ff.vcs == 64'sd0;
      s14_in.den   = cabs;
      s14_in.num   = (94'(s13_ff.nhi) << 32) + 94'(s13_ff.nlo);
      s14_in.x     = s13_ff.x;

      // |a|*x*x / |vcs|, quotient capped at 33 bits
      num = s14_ff.num;
      d2_in[0].chg   = s14_ff.chg;
      d2_in[0].which = s14_ff.which;
      d2_in[0].acc   = s14_ff.acc;
      d2_in[0].dec   = s14_ff.dec;
      d2_in[0].neg   = s14_ff.neg;
      d2_in[0].vz    = s14_ff.vz;
      d2_in[0].big   = 64'(num[93:33]) >= s14_ff.den;
      d2_in[0].den   = s14_ff.den;
      d2_in[0].rem   = d2_in[0].big ? 64'd0 : 64'(num[93:33]);
      d2_in[0].n     = num[32:0];
      d2_in[0].x     = s14_ff.x;
      for (int k = 0; k < DIV2_STAGES; k++) begin
         cur3 = d2_ff[k];
         for (int j = 0; j < DIV2_PER; j++) begin
            t3 = {cur3.rem, cur3.n[32]};
            if (t3 >= {1'b0, cur3.den}) begin
               cur3.rem = 64'(t3 - {1'b0, cur3.den});
               cur3.n   = {cur3.n[31:0], 1'b1};
            end else begin
               cur3.rem = t3[63:0];
               cur3.n   = {cur3.n[31:0], 1'b0};
            end
         end
         d2_in[k+1] = cur3;
      end

      // coast time
      cur3  = d2_ff[DIV2_STAGES];
      q     = cur3.n;
      two_x = {cur3.x, 1'b0};
      s     = '0;
      if (!cur3.neg) begin
         if (cur3.big || (q[32:31] != 2'b00)) begin
            c = COAST_MAX;
         end else begin
            s = 33'(two_x) + q;
            c = (s > 33'(COAST_MAX)) ? COAST_MAX : s[30:0];
         end
      end else begin
         if (cur3.big || (q >= 33'(two_x))) begin
            c = '0;
         end else begin
            s = 33'(two_x) - q;
            c = (s > 33'(COAST_MAX)) ? COAST_MAX : s[30:0];
         end
      end
      if (cur3.chg) begin
         rsp_data_in.updated_plan   = cur3.which;
         rsp_data_in.new_accel_time = cur3.acc;
         rsp_data_in.new_decel_time = cur3.dec;
         rsp_data_in.new_coast_time = cur3.vz ? COAST_MAX : c;
      end else begin
         rsp_data_in = '0;
         rsp_data_in.updated_plan = PLAN_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         s6_ff  <= s6_in;
         for (int k = 0; k <= DIV1_STAGES; k++) begin
            d1_ff[k] <= d1_in[k];
         end
         for (int k = 0; k <= SQRT_STAGES; k++) begin
            sq_ff[k] <= sq_in[k];
         end
         s9_ff  <= s9_in;
         s10_ff <= s10_in;
         s11_ff <= s11_in;
         s12_ff <= s12_in;
         s13_ff <= s13_in;
         s14_ff <= s14_in;
         for (int k = 0; k <= DIV2_STAGES; k++) begin
            d2_ff[k] <= d2_in[k];
         end
      end
      if (out_free) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_vld_ff    <= '0;
         d1_vld_ff    <= '0;
         sq_vld_ff    <= '0;
         sb_vld_ff    <= '0;
         d2_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            sa_vld_ff <= {sa_vld_ff[4:0], req_valid};
            d1_vld_ff <= {d1_vld_ff[DIV1_STAGES-1:0], sa_vld_ff[5]};
            sq_vld_ff <= {sq_vld_ff[SQRT_STAGES-1:0], d1_vld_ff[DIV1_STAGES]};
            sb_vld_ff <= {sb_vld_ff[4:0], sq_vld_ff[SQRT_STAGES]};
            d2_vld_ff <= {d2_vld_ff[DIV2_STAGES-1:0], sb_vld_ff[5]};
         end
         if (out_free) begin
            rsp_valid_ff <= d2_vld_ff[DIV2_STAGES];
         end
      end
   end

endmodule
